### src/mwfc_pkg.sv
package mwfc_pkg;

  localparam int MaxVertices = 64;
  localparam int VIdxW       = $clog2(MaxVertices);
  localparam int CountW      = $clog2(MaxVertices + 1);
  localparam int WeightW     = 31;
  localparam int PairW       = WeightW + 1;
  localparam int SumW        = WeightW + 2;
  localparam int OutW        = 34;

  // Item codes carried in the mode field. The fourth code is ignored.
  typedef enum logic [1:0] {
    ModeLoad  = 2'd0,
    ModeEdge  = 2'd1,
    ModeStart = 2'd2
  } mode_e;

  typedef logic [MaxVertices-1:0] row_t;
  typedef logic [WeightW-1:0]     weight_t;
  typedef logic [VIdxW-1:0]       vidx_t;

endpackage

### src/mwfc_if.sv
interface mwfc_in_if;
  import mwfc_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [VIdxW-1:0]    vertex_a;
  logic [VIdxW-1:0]    vertex_b;
  logic [WeightW-1:0]  weight;

  modport source (output valid, mode, vertex_a, vertex_b, weight, input ready);
  modport sink   (input valid, mode, vertex_a, vertex_b, weight, output ready);
endinterface

interface mwfc_out_if;
  import mwfc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic signed [OutW-1:0] best_sum;

  modport source (output valid, found, best_sum, input ready);
  modport sink   (input valid, found, best_sum, output ready);
endinterface

interface mwfc_cfg_if;
  import mwfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### src/max_weight_four_cycle_search.sv
// Channel  Role   Handshake          Payload
// in_i     sink   valid/ready        mode, vertex_a, vertex_b, weight
// cfg_i    sink   valid/ready        data (vertex_count), always ready
// out_o    source valid/ready        found, best_sum
//
// A weight load is a single write; an edge reads both rows, then writes each back.
// A search walks every pair (p,q) with p below q and scans the common neighbors of each;
// the single read port of the weight memory sets the scan to one neighbor per cycle.
// Reset clears the valid bits of both memories, so every weight and row reads as zero.
// A finished result waits in the output register; loads and edges are still taken, and a
// second search stalls only at its end until the first result has been transferred.
module max_weight_four_cycle_search
  import mwfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mwfc_in_if.sink     in_i,
  mwfc_cfg_if.sink    cfg_i,
  mwfc_out_if.source  out_o
);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_EDGE_A = 10'b00_0000_0010,
    S_EDGE_B = 10'b00_0000_0100,
    S_PLOAD  = 10'b00_0000_1000,
    S_PAIR   = 10'b00_0001_0000,
    S_COMMON = 10'b00_0010_0000,
    S_SCAN   = 10'b00_0100_0000,
    S_SCORE  = 10'b00_1000_0000,
    S_BEST   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // The configuration register. Write it only while the block is idle; the block does not enforce this.
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] n_eff;
  row_t              nmask;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(MaxVertices);
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.data;
    end
  end

  // Counts above the vertex limit behave as the limit.
  assign n_eff = (count_q > CountW'(MaxVertices)) ? CountW'(MaxVertices) : count_q;

  // Vertices at or beyond the count are masked out of every common-neighbor set.
  always_comb begin
    for (int i = 0; i < MaxVertices; i++) begin
      nmask[i] = (CountW'(i) < n_eff);
    end
  end

  // Adjacency memory: one write port, two read ports with registered data.
  row_t  adj_mem [MaxVertices];
  row_t  adj_vld_q;
  logic  adj_re;
  vidx_t adj_ra0, adj_ra1;
  logic  adj_we;
  vidx_t adj_wa;
  row_t  adj_wd;
  row_t  adj_rdata0_q, adj_rdata1_q;
  logic  adj_rvld0_q, adj_rvld1_q;
  row_t  adj_rd0, adj_rd1;

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rdata0_q <= adj_mem[adj_ra0];
      adj_rdata1_q <= adj_mem[adj_ra1];
    end
  end

  // A row that was never written since reset reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q   <= '0;
      adj_rvld0_q <= 1'b0;
      adj_rvld1_q <= 1'b0;
    end else begin
      if (adj_we) begin
        adj_vld_q[adj_wa] <= 1'b1;
      end
      if (adj_re) begin
        adj_rvld0_q <= adj_vld_q[adj_ra0];
        adj_rvld1_q <= adj_vld_q[adj_ra1];
      end
    end
  end

  assign adj_rd0 = adj_rvld0_q ? adj_rdata0_q : '0;
  assign adj_rd1 = adj_rvld1_q ? adj_rdata1_q : '0;

  // Weight memory: one write port, one read port with registered data.
  weight_t w_mem [MaxVertices];
  row_t    w_vld_q;
  logic    w_re;
  vidx_t   w_ra;
  logic    w_we;
  weight_t w_rdata_q;
  logic    w_rvld_q;
  weight_t w_rd;

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[in_i.vertex_a] <= in_i.weight;
    end
    if (w_re) begin
      w_rdata_q <= w_mem[w_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q  <= '0;
      w_rvld_q <= 1'b0;
    end else begin
      if (w_we) begin
        w_vld_q[in_i.vertex_a] <= 1'b1;
      end
      if (w_re) begin
        w_rvld_q <= w_vld_q[w_ra];
      end
    end
  end

  assign w_rd = w_rvld_q ? w_rdata_q : '0;

  // Datapath registers.
  vidx_t          ea_q, eb_q, ea_d, eb_d;
  vidx_t          p_q, q_q, p_d, q_d;
  logic           p_fresh_q, p_fresh_d;
  weight_t        wp_q, wp_d;
  logic [PairW-1:0] wpq_q, wpq_d;
  row_t           mask_q, mask_d;
  logic           pend_q, pend_d;
  weight_t        top_q, top_d, next_q, next_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic           score_ok_q, score_ok_d;
  logic [SumW-1:0] best_q, best_d;
  logic           found_q, found_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_found_q, out_found_d;
  logic signed [OutW-1:0] out_sum_q, out_sum_d;

  // Lowest set bit of the pending neighbor mask and its index.
  row_t  lsb;
  vidx_t lsb_idx;

  assign lsb = mask_q & (~mask_q + row_t'(1));

  always_comb begin
    lsb_idx = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      if (lsb[i]) begin
        lsb_idx = lsb_idx | VIdxW'(i);
      end
    end
  end

  logic in_fire;
  logic q_last, p_more;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // Last partner for this p, and whether another p still has a partner above it.
  assign q_last = ({1'b0, q_q} == (n_eff - CountW'(1)));
  assign p_more = (({1'b0, p_q} + CountW'(2)) < n_eff);

  always_comb begin
    state_d     = state_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    p_d         = p_q;
    q_d         = q_q;
    p_fresh_d   = p_fresh_q;
    wp_d        = wp_q;
    wpq_d       = wpq_q;
    mask_d      = mask_q;
    pend_d      = 1'b0;
    top_d       = top_q;
    next_d      = next_q;
    sum_d       = sum_q;
    score_ok_d  = score_ok_q;
    best_d      = best_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_found_d = out_found_q;
    out_sum_d   = out_sum_q;

    adj_re  = 1'b0;
    adj_ra0 = in_i.vertex_a;
    adj_ra1 = in_i.vertex_b;
    adj_we  = 1'b0;
    adj_wa  = ea_q;
    adj_wd  = adj_rd0 | (row_t'(1) << eb_q);
    w_re    = 1'b0;
    w_ra    = p_q;
    w_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_e'(in_i.mode))
            ModeLoad: begin
              w_we = 1'b1;
            end
            ModeEdge: begin
              // A self loop leaves the matrix unchanged.
              if (in_i.vertex_a != in_i.vertex_b) begin
                adj_re  = 1'b1;
                ea_d    = in_i.vertex_a;
                eb_d    = in_i.vertex_b;
                state_d = S_EDGE_A;
              end
            end
            ModeStart: begin
              found_d = 1'b0;
              p_d     = '0;
              q_d     = vidx_t'(1);
              if (n_eff < CountW'(2)) begin
                state_d = S_DONE;
              end else begin
                state_d = S_PLOAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE_A: begin
        adj_we  = 1'b1;
        state_d = S_EDGE_B;
      end
      S_EDGE_B: begin
        adj_we  = 1'b1;
        adj_wa  = eb_q;
        adj_wd  = adj_rd1 | (row_t'(1) << ea_q);
        state_d = S_IDLE;
      end
      S_PLOAD: begin
        w_re      = 1'b1;
        p_fresh_d = 1'b1;
        state_d   = S_PAIR;
      end
      S_PAIR: begin
        if (p_fresh_q) begin
          wp_d = w_rd;
        end
        p_fresh_d = 1'b0;
        adj_re    = 1'b1;
        adj_ra0   = p_q;
        adj_ra1   = q_q;
        w_re      = 1'b1;
        w_ra      = q_q;
        state_d   = S_COMMON;
      end
      S_COMMON: begin
        mask_d  = adj_rd0 & adj_rd1 & nmask;
        wpq_d   = {1'b0, wp_q} + {1'b0, w_rd};
        top_d   = '0;
        next_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // Fold in the weight read in the previous cycle.
        if (pend_q) begin
          if (w_rd >= top_q) begin
            next_d = top_q;
            top_d  = w_rd;
          end else if (w_rd > next_q) begin
            next_d = w_rd;
          end
        end
        if (mask_q != '0) begin
          w_re   = 1'b1;
          w_ra   = lsb_idx;
          pend_d = 1'b1;
          mask_d = mask_q & ~lsb;
        end else begin
          state_d = S_SCORE;
        end
      end
      S_SCORE: begin
        sum_d      = SumW'(wpq_q) + SumW'(top_q) + SumW'(next_q);
        score_ok_d = (next_q != '0);
        state_d    = S_BEST;
      end
      S_BEST: begin
        if (score_ok_q && (!found_q || (sum_q > best_q))) begin
          best_d  = sum_q;
          found_d = 1'b1;
        end
        if (!q_last) begin
          q_d     = q_q + vidx_t'(1);
          state_d = S_PAIR;
        end else if (p_more) begin
          p_d     = p_q + vidx_t'(1);
          q_d     = p_q + vidx_t'(2);
          state_d = S_PLOAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_sum_d   = found_q ? OutW'(best_q) : '1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      p_fresh_q   <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      p_fresh_q   <= p_fresh_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q        <= ea_d;
    eb_q        <= eb_d;
    p_q         <= p_d;
    q_q         <= q_d;
    wp_q        <= wp_d;
    wpq_q       <= wpq_d;
    mask_q      <= mask_d;
    top_q       <= top_d;
    next_q      <= next_d;
    sum_q       <= sum_d;
    score_ok_q  <= score_ok_d;
    best_q      <= best_d;
    out_found_q <= out_found_d;
    out_sum_q   <= out_sum_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.found    = out_found_q;
  assign out_o.best_sum = out_sum_q;

`ifndef SYNTHESIS
  // A pair under scan always has its first vertex below its second.
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAIR) |-> (p_q < q_q))
    else $error("pair indices out of order");

  // No vertex beyond the count ever enters the neighbor scan.
  a_mask_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((mask_q & ~nmask) == '0))
    else $error("neighbor mask holds an unused vertex");

  // The top weight never falls below the runner-up.
  a_top_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (top_q >= next_q))
    else $error("top two weights out of order");

  // Once the output register is free, a finished search hands over its result.
  a_done_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished search did not deliver its result");
`endif

endmodule

### verif/max_weight_four_cycle_search_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the block that searches for the heaviest square of four vertices.
// A driver process feeds graph items (weight loads, edges, searches and the
// unused code) from a queue that the stimulus process fills. A monitor process
// takes the search reports. Both sides insert random gaps. Every accepted item
// also updates a private copy of the graph. Every accepted search computes the
// expected report from that copy and queues it for the monitor.
module max_weight_four_cycle_search_test;
  import mwfc_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 7;
  // An edge produces no report, so a short settle time covers any edge
  // write that is still in flight.
  localparam int SettleCycles  = 12;
  // The slowest search here is a dense 64-vertex graph with 2016 pairs, each
  // scanning up to 62 common neighbors. The limit leaves a wide margin above that.
  localparam int IdleLimit     = 1000000;
  localparam int HoldCycles    = 700;
  localparam int ItemsPerPhase = 75;
  localparam int NumPhases     = 16;
  localparam int PressurePhase = 6;
  localparam int ReportLimit   = 10;

  // This code is not part of the package enum. The block must ignore it.
  localparam logic [1:0] ModeUnused = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    vidx_t      a;
    vidx_t      b;
    weight_t    w;
  } graph_item_t;

  typedef struct packed {
    logic            found;
    logic [OutW-1:0] sum;
  } cycle_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mwfc_in_if  in_ch ();
  mwfc_cfg_if cfg_ch ();
  mwfc_out_if out_ch ();

  max_weight_four_cycle_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // The bench's own copy of the graph and of the vertex count register.
  weight_t     weight_copy [MaxVertices];
  row_t        adjacency_copy [MaxVertices];
  int unsigned vertex_count_copy;

  graph_item_t   pending_items [$];
  cycle_report_t expected_reports [$];

  int fail_count    = 0;
  int hold_requests = 0;
  bit calm_phase    = 1'b0;

  // A failure is always counted. Only the first few get a full printout.
  task automatic flag_fault(input string what);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("mismatch: %s", what);
    end
  endtask

  // Gap lengths are mostly zero or short, with a long one now and then.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Weights favor zero, the maximum and small values that tie with each
  // other. Ties matter because an equal weight pushes the old top down.
  function automatic weight_t pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 40) return weight_t'($urandom_range(1, 3));
    if (r < 50) return weight_t'(1) << $urandom_range(0, WeightW - 1);
    return weight_t'($urandom());
  endfunction

  // Most vertices fall inside the active range so that the graph gets
  // dense there. The rest land anywhere and must be skipped by the search.
  function automatic vidx_t pick_vertex(input int count);
    int lim;
    lim = (count > MaxVertices) ? MaxVertices : count;
    if (lim > 0 && $urandom_range(0, 99) < 88) return vidx_t'($urandom_range(0, lim - 1));
    return vidx_t'($urandom_range(0, MaxVertices - 1));
  endfunction

  // Computes the best pair score over all vertex pairs in use, or -1. For
  // each pair the two heaviest common neighbors are tracked. A pair scores
  // only when the second of them is nonzero.
  function automatic longint heaviest_four_cycle();
    int     n;
    longint best;
    longint top;
    longint second;
    longint wv;
    row_t   shared;
    n = (vertex_count_copy > MaxVertices) ? MaxVertices : int'(vertex_count_copy);
    best = -1;
    for (int p = 0; p < n; p++) begin
      for (int q = p + 1; q < n; q++) begin
        shared = adjacency_copy[p] & adjacency_copy[q];
        top = 0;
        second = 0;
        for (int v = 0; v < n; v++) begin
          if (shared[v]) begin
            wv = weight_copy[v];
            if (wv >= top) begin
              second = top;
              top = wv;
            end else if (wv > second) begin
              second = wv;
            end
          end
        end
        if (second != 0) begin
          wv = weight_copy[p];
          wv = wv + weight_copy[q] + top + second;
          if (wv > best) best = wv;
        end
      end
    end
    return best;
  endfunction

  // Applies one accepted item to the graph copy. For a search, it queues
  // the report that the block must produce.
  task automatic absorb_item(input graph_item_t it);
    longint        best;
    cycle_report_t rep;
    case (it.mode)
      ModeLoad: begin
        weight_copy[it.a] = it.w;
      end
      ModeEdge: begin
        // Self loops never reach the matrix. Duplicates set a bit that is already set.
        if (it.a != it.b) begin
          adjacency_copy[it.a][it.b] = 1'b1;
          adjacency_copy[it.b][it.a] = 1'b1;
        end
      end
      ModeStart: begin
        best = heaviest_four_cycle();
        rep.found = (best >= 0);
        rep.sum = best[OutW-1:0];
        expected_reports.insert(expected_reports.size(), rep);
      end
      default: begin
      end
    endcase
  endtask

  task automatic offer(input logic [1:0] mode, input int a, input int b, input weight_t w);
    graph_item_t it;
    it.mode = mode;
    it.a = vidx_t'(a);
    it.b = vidx_t'(b);
    it.w = w;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Fills one phase of stimulus. The phase builds up the graph with random
  // content, mostly inside the active vertex range. Self loops, the unused
  // code and vertices beyond the range serve as noise. The fields that an
  // item ignores carry random bits. Large vertex counts make searches slow,
  // so those phases get only a few of them. Every phase ends with a search.
  task automatic queue_random_phase(input int count, input int items, input int start_cap);
    int          starts;
    int          r;
    graph_item_t it;
    starts = 0;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      it.a = vidx_t'($urandom());
      it.b = vidx_t'($urandom());
      it.w = weight_t'($urandom());
      if (r < 34) begin
        it.mode = ModeLoad;
        it.a = pick_vertex(count);
        it.w = pick_weight();
      end else if (r < 80) begin
        it.mode = ModeEdge;
        it.a = pick_vertex(count);
        it.b = ($urandom_range(0, 9) == 0) ? it.a : pick_vertex(count);
      end else if (r < 84) begin
        it.mode = ModeUnused;
      end else if (starts < start_cap) begin
        it.mode = ModeStart;
        starts++;
      end else begin
        it.mode = ModeLoad;
        it.a = pick_vertex(count);
        it.w = pick_weight();
      end
      pending_items.insert(pending_items.size(), it);
    end
    offer(ModeStart, $urandom(), $urandom(), weight_t'($urandom()));
  endtask

  // Waits until every item is taken and every report is back. It then
  // waits out the settle time so that a trailing edge write can finish.
  task automatic settle();
    while (pending_items.size() != 0 || expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The count register may only change while the block is idle.
  task automatic write_vertex_count(input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= CountW'(value);
    do @(posedge clk_i); while (!cfg_ch.ready);
    vertex_count_copy = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Driver: offers the item at the head of the pending queue. After each
  // transfer it may drop valid for a random number of cycles. While valid
  // is high the payload holds steady, so each step assigns valid only once.
  int send_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid    <= 1'b0;
      in_ch.mode     <= '0;
      in_ch.vertex_a <= '0;
      in_ch.vertex_b <= '0;
      in_ch.weight   <= '0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        absorb_item(pending_items.pop_front());
        send_gap = calm_phase ? 0 : pick_gap();
      end else if (!in_ch.valid && send_gap > 0) begin
        send_gap--;
      end
      if (send_gap == 0 && pending_items.size() != 0) begin
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= pending_items[0].mode;
        in_ch.vertex_a <= pending_items[0].a;
        in_ch.vertex_b <= pending_items[0].b;
        in_ch.weight   <= pending_items[0].w;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: takes reports and checks them in order against the expected
  // queue. Ready drops for random gaps. On request it also holds off for a
  // long stretch. During that stretch a finished report stays in the block,
  // the next search stalls at its end, and the input path backs up.
  int recv_gap;
  int hold_left;
  int holds_served;

  always @(posedge clk_i or negedge rst_ni) begin
    cycle_report_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
      holds_served = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          flag_fault($sformatf("report with nothing expected: found=%b best_sum=%0d",
                               out_ch.found, out_ch.best_sum));
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.found !== want.found) begin
            flag_fault($sformatf("found: expected %b, got %b", want.found, out_ch.found));
          end
          if (out_ch.best_sum !== want.sum) begin
            flag_fault($sformatf("best_sum: expected %0d, got %0d",
                                 $signed(want.sum), out_ch.best_sum));
          end
        end
        recv_gap = calm_phase ? 0 : pick_gap();
      end
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles without any transfer on any channel.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The phase plan runs through the smallest counts, which have no pair at
  // all, through small and medium graphs, up to the full size and a count
  // above it that must be clamped.
  int phase_counts [NumPhases] = '{1, 0, 2, 3, 4, 5, 6, 8, 12, 16, 24, 7, 64, 127, 10, 4};

  initial begin
    rst_ni       <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    for (int i = 0; i < MaxVertices; i++) begin
      weight_copy[i] = '0;
      adjacency_copy[i] = '0;
    end
    vertex_count_copy = MaxVertices;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The count keeps its reset value of 64.
    // A search on the empty graph must report nothing found.
    offer(ModeStart, 0, 0, '0);
    // A square 0-1-2-3 with all weights at the maximum gives the largest sum.
    offer(ModeLoad, 0, 63, '1);
    offer(ModeLoad, 1, 0, '1);
    offer(ModeLoad, 2, 0, '1);
    offer(ModeLoad, 3, 0, '1);
    offer(ModeEdge, 0, 1, '0);
    offer(ModeEdge, 1, 2, '1);
    offer(ModeEdge, 2, 3, '0);
    offer(ModeEdge, 3, 0, '0);
    // A duplicate edge, a self loop and the unused code must all leave the graph as it is.
    offer(ModeEdge, 1, 0, '0);
    offer(ModeEdge, 5, 5, '0);
    offer(ModeUnused, 0, 2, '1);
    offer(ModeStart, 63, 63, '1);
    // A zero weight on one corner removes one diagonal pair but keeps the other.
    offer(ModeLoad, 2, 0, '0);
    offer(ModeStart, 0, 0, '0);
    // The top vertex joins as a third common neighbor of 1 and 3.
    offer(ModeLoad, 63, 0, weight_t'(1));
    offer(ModeEdge, 63, 1, '0);
    offer(ModeEdge, 3, 63, '0);
    offer(ModeStart, 0, 0, '0);
    // Equal neighbor weights test that a tie moves the old top down.
    offer(ModeLoad, 0, 0, weight_t'(7));
    offer(ModeLoad, 2, 0, weight_t'(7));
    offer(ModeStart, 0, 0, '0);
    settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_vertex_count(phase_counts[ph]);
      calm_phase = (ph % 4 == 3);
      if (ph == PressurePhase) begin
        // Three searches in a row against a long receiver hold-off fill the block up.
        hold_requests++;
        repeat (3) offer(ModeStart, $urandom(), $urandom(), weight_t'($urandom()));
      end
      queue_random_phase(phase_counts[ph], ItemsPerPhase,
                         (phase_counts[ph] > 24) ? 1 : ItemsPerPhase);
      settle();
    end

    if (expected_reports.size() != 0) begin
      flag_fault($sformatf("%0d reports never arrived", expected_reports.size()));
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
